>>> rtl/xbc_pkg.sv
// ----------------------------------------------------------------------------
// xbc_pkg
// Shared types and constants for the XTEA block cipher unit.
// ----------------------------------------------------------------------------
package xbc_pkg;

  localparam int WORD_W  = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3      = 3'd4;

  // direction codes
  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } block_t;

  typedef struct packed {
    logic                   dir;
    logic [3:0][WORD_W-1:0] key;
  } cfg_t;

endpackage

>>> rtl/xtea_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// xtea_block_cipher_unit
// XTEA encrypt/decrypt of 64-bit blocks, one half-round per pipeline cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: block_word0/block_word1 with in_valid/in_stall. A
//   transaction is taken at a rising edge with in_valid high, in_stall low.
//   Output channel: result_word0/result_word1 with out_valid/out_stall.
//   Configuration: cfg_write, cfg_index, cfg_data. Index 0 is direction
//   (0 encrypt, 1 decrypt), indexes 1..4 are key words 0..3. Write only
//   while no block is in flight; other indexes are ignored.
//   Pipeline: one register per cell in a chain of 2*ROUNDS cells, every cell
//   its own register stage. Throughput: one block per cycle while the
//   output is not stalled.
//   Stall: a stalled result holds in the last cell. Earlier cells keep
//   moving into empty slots, so the input stalls only once the chain is full.
//   Reset: empties the chain and clears direction and key words to zero.
// ----------------------------------------------------------------------------
module xtea_block_cipher_unit
  import xbc_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_W-1:0]    block_word0,
  input  logic [WORD_W-1:0]    block_word1,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    result_word0,
  output logic [WORD_W-1:0]    result_word1
);

  localparam int CELLS = 2 * ROUNDS;

  logic              direction;
  logic [WORD_W-1:0] key_word0;
  logic [WORD_W-1:0] key_word1;
  logic [WORD_W-1:0] key_word2;
  logic [WORD_W-1:0] key_word3;
  cfg_t              cfg;

  logic   valid_chain [0:CELLS];
  logic   ready_chain [0:CELLS];
  block_t data_chain  [0:CELLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCRYPT;
      key_word0 <= '0;
      key_word1 <= '0;
      key_word2 <= '0;
      key_word3 <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIRECTION: direction <= cfg_data[0];
        REG_KEY0:      key_word0 <= cfg_data;
        REG_KEY1:      key_word1 <= cfg_data;
        REG_KEY2:      key_word2 <= cfg_data;
        REG_KEY3:      key_word3 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.dir    = direction;
    cfg.key[0] = key_word0;
    cfg.key[1] = key_word1;
    cfg.key[2] = key_word2;
    cfg.key[3] = key_word3;
  end

  assign valid_chain[0]    = in_valid;
  assign data_chain[0].v0  = block_word0;
  assign data_chain[0].v1  = block_word1;
  assign in_stall          = !ready_chain[0];
  assign ready_chain[CELLS] = !out_stall;
  assign out_valid         = valid_chain[CELLS];
  assign result_word0      = data_chain[CELLS].v0;
  assign result_word1      = data_chain[CELLS].v1;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    xbc_cell #(
      .ROUNDS (ROUNDS),
      .STAGE  (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .in_valid  (valid_chain[i]),
      .in_ready  (ready_chain[i]),
      .in_data   (data_chain[i]),
      .out_valid (valid_chain[i+1]),
      .out_ready (ready_chain[i+1]),
      .out_data  (data_chain[i+1])
    );
  end

`ifndef SYNTHESIS
  // an empty or draining last cell frees the whole chain
  a_no_stall_when_draining: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while the chain could advance");

  a_first_cell_loaded: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> valid_chain[1])
    else $error("accepted transaction missing from first cell");

  a_direction_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index == REG_DIRECTION) |=> (direction == $past(cfg_data[0])))
    else $error("direction register not updated");
`endif

endmodule

>>> rtl/xbc_cell.sv
// ----------------------------------------------------------------------------
// xbc_cell
// One half-round of XTEA. The sum for this position is a constant for each
// direction; the cell mixes one word into the other and hands the block on.
// ----------------------------------------------------------------------------
module xbc_cell
  import xbc_pkg::*;
#(
  parameter int ROUNDS = 32,
  parameter int STAGE  = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_ready,
  input  block_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output block_t out_data
);

  localparam int   N   = STAGE / 2;
  localparam logic ODD = 1'(STAGE % 2);

  localparam logic [63:0] ENC_MUL  = 64'(ODD ? N + 1 : N);
  localparam logic [63:0] DEC_MUL  = 64'(ODD ? ROUNDS - N - 1 : ROUNDS - N);
  localparam logic [63:0] ENC_PROD = ENC_MUL * 64'(DELTA);
  localparam logic [63:0] DEC_PROD = DEC_MUL * 64'(DELTA);
  localparam logic [WORD_W-1:0] ENC_SUM = ENC_PROD[WORD_W-1:0];
  localparam logic [WORD_W-1:0] DEC_SUM = DEC_PROD[WORD_W-1:0];

  // encrypt keys off sum[1:0], then sum[12:11]; decrypt uses the reverse order
  localparam logic [1:0] ENC_KSEL = ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
  localparam logic [1:0] DEC_KSEL = ODD ? DEC_SUM[1:0]   : DEC_SUM[12:11];

  logic              upd_hi;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] sum;
  logic [1:0]        ksel;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] dst_new;
  block_t            data_next;

  always_comb begin
    // v1 is the target when exactly one of (second half, decrypt) holds
    upd_hi  = ODD ^ (cfg.dir == DIR_DECRYPT);
    src     = upd_hi ? in_data.v0 : in_data.v1;
    dst     = upd_hi ? in_data.v1 : in_data.v0;
    sum     = (cfg.dir == DIR_DECRYPT) ? DEC_SUM : ENC_SUM;
    ksel    = (cfg.dir == DIR_DECRYPT) ? DEC_KSEL : ENC_KSEL;
    mix     = (((src << 4) ^ (src >> 5)) + src) ^ (sum + cfg.key[ksel]);
    dst_new = (cfg.dir == DIR_DECRYPT) ? dst - mix : dst + mix;
    data_next = in_data;
    if (upd_hi) begin
      data_next.v1 = dst_new;
    end else begin
      data_next.v0 = dst_new;
    end
  end

  // take a new transaction when empty or when the neighbor drains this one
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
